>>> src/cidl_pkg.sv
// ----------------------------------------------------------------------------
// cidl_pkg
// Shared types and codes for the card ID lookup-or-register unit.
// ----------------------------------------------------------------------------
package cidl_pkg;

    localparam int ID_W      = 32;
    localparam int NUM_OUT_W = 5;
    localparam int ST_W      = 3;

    // opcode values
    localparam logic OP_DETECT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam logic [ST_W-1:0] ST_KNOWN   = 3'd0;
    localparam logic [ST_W-1:0] ST_ADDED   = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
    localparam logic [ST_W-1:0] ST_REPEAT  = 3'd3;
    localparam logic [ST_W-1:0] ST_REMOVED = 3'd4;

    // search probe handed from cell to cell
    typedef struct packed {
        logic            valid;
        logic            hit;
        logic [ID_W-1:0] key;
    } probe_t;

endpackage

>>> src/cidl_cell.sv
// ----------------------------------------------------------------------------
// cidl_cell
// One table entry: holds a card ID, compares it against the passing probe
// and hands the probe on to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module cidl_cell #(
    parameter int IDX   = 0,
    parameter int NUM_W = 5
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [NUM_W-1:0]            entry_count,
    input  logic                        wr_en,
    input  logic [cidl_pkg::ID_W-1:0]   wr_id,
    input  cidl_pkg::probe_t            probe_in,
    input  logic [NUM_W-1:0]            num_in,
    output cidl_pkg::probe_t            probe_out,
    output logic [NUM_W-1:0]            num_out
);
    import cidl_pkg::*;

    localparam logic [NUM_W-1:0] MY_IDX = NUM_W'(IDX);
    localparam logic [NUM_W-1:0] MY_NUM = NUM_W'(IDX + 1);

    logic [ID_W-1:0]  id_reg;
    probe_t           probe_reg;
    probe_t           probe_next;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] num_next;
    logic             match;

    // entry is live only below the fill count
    assign match = probe_in.valid && !probe_in.hit
                   && (entry_count > MY_IDX) && (id_reg == probe_in.key);

    always_comb begin
        probe_next = probe_in;
        num_next   = num_in;
        if (match) begin
            probe_next.hit = 1'b1;
            num_next       = MY_NUM;
        end
    end

    // stored ID: written when this is the next free slot
    always_ff @(posedge aclk) begin
        if (wr_en && (entry_count == MY_IDX)) begin
            id_reg <= wr_id;
        end
    end

    // probe stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg <= '0;
        end else begin
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
    end

    assign probe_out = probe_reg;
    assign num_out   = num_reg;

endmodule

>>> src/card_id_lookup_or_register_unit.sv
// ----------------------------------------------------------------------------
// card_id_lookup_or_register_unit
// Registry of card IDs: looks up a detected ID and appends it when new and the table has room.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | s_valid s_ready s_opcode s_card_id             | in
//  result  | m_valid m_ready m_assigned_number m_status     | out
//          | m_card_present                                 |
//
// For a new-ID detection the probe walks all MAX_ENTRIES cells of the chain one cell
// per cycle; repeats and removals skip the chain and go straight to the result.
// One word is in work at a time; s_ready is high whenever no word is in work,
// also while a finished result waits in the output register.
// Reset (aresetn low, synchronous) empties the table and clears the last ID.
// A stalled m_ready holds the result and stops the next word at its end.
// ----------------------------------------------------------------------------
module card_id_lookup_or_register_unit #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_opcode,
    input  logic [cidl_pkg::ID_W-1:0]        s_card_id,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [cidl_pkg::NUM_OUT_W-1:0]   m_assigned_number,
    output logic [cidl_pkg::ST_W-1:0]        m_status,
    output logic                             m_card_present
);
    import cidl_pkg::*;

    localparam int NUM_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [NUM_W-1:0] FULL_COUNT = NUM_W'(MAX_ENTRIES);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DONE   = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [NUM_W-1:0] count_reg, count_next;
    logic [ID_W-1:0]  last_id_reg, last_id_next;
    logic             last_valid_reg, last_valid_next;
    logic             present_reg, present_next;
    logic [NUM_W-1:0] pend_num_reg, pend_num_next;
    logic [ST_W-1:0]  pend_status_reg, pend_status_next;
    logic             m_valid_reg, m_valid_next;
    logic [NUM_OUT_W-1:0] m_num_reg, m_num_next;
    logic [ST_W-1:0]  m_status_reg, m_status_next;
    logic             m_present_reg, m_present_next;

    logic             accept;
    logic             is_repeat;
    logic             wr_en;
    logic             out_free;
    logic [NUM_W+NUM_OUT_W-1:0] num_ext;

    probe_t           probe_chain [0:MAX_ENTRIES];
    logic [NUM_W-1:0] num_chain   [0:MAX_ENTRIES];
    probe_t           probe_exit;
    logic [NUM_W-1:0] num_exit;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign is_repeat = last_valid_reg && (s_card_id == last_id_reg);
    assign out_free  = !m_valid_reg || m_ready;

    // launch a probe into the first cell for a new-ID detection
    assign probe_chain[0].valid = accept && (s_opcode == OP_DETECT) && !is_repeat;
    assign probe_chain[0].hit   = 1'b0;
    assign probe_chain[0].key   = s_card_id;
    assign num_chain[0] = '0;

    // cell chain
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        cidl_cell #(
            .IDX   (i),
            .NUM_W (NUM_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .entry_count (count_reg),
            .wr_en       (wr_en),
            .wr_id       (probe_exit.key),
            .probe_in    (probe_chain[i]),
            .num_in      (num_chain[i]),
            .probe_out   (probe_chain[i+1]),
            .num_out     (num_chain[i+1])
        );
    end

    assign probe_exit = probe_chain[MAX_ENTRIES];
    assign num_exit   = num_chain[MAX_ENTRIES];

    // append on a miss when there is room
    assign wr_en = (state_reg == S_SEARCH) && probe_exit.valid && !probe_exit.hit
                   && (count_reg != FULL_COUNT);

    // number field wraps to the output width
    assign num_ext = {{NUM_OUT_W{1'b0}}, pend_num_reg};

    // control
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        last_id_next     = last_id_reg;
        last_valid_next  = last_valid_reg;
        present_next     = present_reg;
        pend_num_next    = pend_num_reg;
        pend_status_next = pend_status_reg;
        m_valid_next     = m_valid_reg;
        m_num_next       = m_num_reg;
        m_status_next    = m_status_reg;
        m_present_next   = m_present_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    pend_num_next = '0;
                    if (s_opcode == OP_REMOVE) begin
                        present_next     = 1'b0;
                        pend_status_next = ST_REMOVED;
                        state_next       = S_DONE;
                    end else begin
                        present_next = 1'b1;
                        if (is_repeat) begin
                            pend_status_next = ST_REPEAT;
                            state_next       = S_DONE;
                        end else begin
                            last_id_next    = s_card_id;
                            last_valid_next = 1'b1;
                            state_next      = S_SEARCH;
                        end
                    end
                end
            end
            S_SEARCH: begin
                if (probe_exit.valid) begin
                    state_next = S_DONE;
                    if (probe_exit.hit) begin
                        pend_num_next    = num_exit;
                        pend_status_next = ST_KNOWN;
                    end else if (count_reg != FULL_COUNT) begin
                        count_next       = count_reg + 1'b1;
                        pend_num_next    = count_reg + 1'b1;
                        pend_status_next = ST_ADDED;
                    end else begin
                        pend_num_next    = '0;
                        pend_status_next = ST_FULL;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_num_next     = num_ext[NUM_OUT_W-1:0];
                    m_status_next  = pend_status_reg;
                    m_present_next = present_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            last_id_reg    <= '0;
            last_valid_reg <= 1'b0;
            present_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            last_id_reg    <= last_id_next;
            last_valid_reg <= last_valid_next;
            present_reg    <= present_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_num_reg    <= pend_num_next;
        pend_status_reg <= pend_status_next;
        m_num_reg       <= m_num_next;
        m_status_reg    <= m_status_next;
        m_present_reg   <= m_present_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_assigned_number = m_num_reg;
    assign m_status          = m_status_reg;
    assign m_card_present    = m_present_reg;

endmodule

>>> src/cidl_checker.sv
// ----------------------------------------------------------------------------
// cidl_checker
// Port-level checks of the card ID lookup-or-register unit.
// ----------------------------------------------------------------------------
module cidl_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [cidl_pkg::NUM_OUT_W-1:0]   m_assigned_number,
    input logic [cidl_pkg::ST_W-1:0]        m_status,
    input logic                             m_card_present
);
    import cidl_pkg::*;

    // one word in work at a time
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    // removal reports no card and no number
    a_removed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_REMOVED) |-> !m_card_present && (m_assigned_number == '0))
        else $error("removal result malformed");

    // any detection leaves the card present
    a_present: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_REMOVED) |-> m_card_present)
        else $error("detection without card present");

    // full and repeat carry number zero
    a_zero_num: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_status == ST_FULL) || (m_status == ST_REPEAT))
        |-> (m_assigned_number == '0))
        else $error("nonzero number on full or repeat");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
        && $stable(m_assigned_number))
        else $error("result changed while stalled");

endmodule

bind card_id_lookup_or_register_unit cidl_checker u_cidl_checker (.*);
